/* rtl/core/quality_trim_point_finder_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quality trim point finder core
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUALITY_TRIM_POINT_FINDER_CORE_ASSERT_SVH
`define QUALITY_TRIM_POINT_FINDER_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define QTPF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition at one edge implies a condition at the next edge
`define QTPF_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/core/qtpf_pkg.sv */
// ----------------------------------------------------------------------------
// Quality trim point finder package
// Widths, constants, register indexes and the result word layout.
// ----------------------------------------------------------------------------
package qtpf_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int COUNT_W   = $clog2(MAX_LEN + 1);
    localparam int TRIM_W    = 11;
    localparam int LEN_W     = (COUNT_W > TRIM_W) ? COUNT_W : TRIM_W;
    localparam int SUM_W     = 20;
    localparam int CHAR_W    = 8;
    localparam int THR_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    localparam logic [CHAR_W:0]    OFFSET_SANGER_IN = 9'd64;
    localparam logic [CHAR_W:0]    OFFSET_STD_IN    = 9'd33;
    localparam logic [CHAR_W-1:0]  SANGER_SHIFT     = 8'd31;
    localparam logic [TRIM_W-1:0]  MIN_KEEP_RESET   = 11'd36;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUALITY_THRESHOLD = 2'd0,
        CFG_SANGER_CONVERT    = 2'd1,
        CFG_MIN_KEEP_LENGTH   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [4:0]        pad;
        logic [TRIM_W-1:0] trim_length;
        logic [CHAR_W-1:0] quality_out;
    } out_word_t;

endpackage

/* rtl/core/quality_trim_point_finder_core.sv */
// ----------------------------------------------------------------------------
// Quality trim point finder core
// Finds the 3' quality trim length of each read from its quality characters.
// ----------------------------------------------------------------------------
// Takes one quality character per cycle on the slave side unless the master
// side stalls, with tlast on the last character of a read, and presents one
// word per character, through the input and result registers, on the master
// side: the character (less 31 with Sanger conversion on) and, on the last
// character, the trim length flagged by tuser. The rate is set by the
// combinational prefix-sum accumulate, saturate and minimum update between
// the input register and the result register. Configuration is taken at any
// time on the cfg channel and must only be changed while no read is in flight.
`include "quality_trim_point_finder_core_assert.svh"

module quality_trim_point_finder_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [qtpf_pkg::CHAR_W-1:0]     s_tdata,    // [7:0] quality_char
    input  logic                            s_tlast,    // last_char
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,    // [7:0] quality_out, [18:8] trim_length
    output logic                            m_tuser,    // length_valid
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qtpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qtpf_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import qtpf_pkg::*;

    logic [THR_W-1:0]         threshold_reg;
    logic                     sanger_reg;
    logic [TRIM_W-1:0]        min_keep_reg;

    logic                     in_valid_reg;
    logic [CHAR_W-1:0]        in_char_reg;
    logic                     in_last_reg;

    logic [COUNT_W-1:0]       position_count_reg, position_count_next;
    logic signed [SUM_W-1:0]  prefix_sum_reg, prefix_sum_next;
    logic signed [SUM_W-1:0]  min_prefix_reg, min_prefix_next;
    logic [COUNT_W-1:0]       min_position_reg, min_position_next;

    logic                     out_valid_reg;
    out_word_t                out_word_reg, out_word_next;
    logic                     out_flag_reg;

    logic                     advance;
    logic signed [CHAR_W:0]   quality;
    logic signed [CHAR_W+1:0] delta;
    logic signed [SUM_W:0]    sum_wide;
    logic                     candidate;
    logic [COUNT_W-1:0]       trim_pos;
    logic [LEN_W-1:0]         keep_len;
    logic [LEN_W-1:0]         len_val;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_flag_reg;

    always_comb
    begin
        quality = $signed({1'b0, in_char_reg})
                - $signed(sanger_reg ? OFFSET_SANGER_IN : OFFSET_STD_IN);
        delta   = $signed({3'b000, threshold_reg}) - $signed({quality[CHAR_W], quality});

        candidate = (position_count_reg != '0)
                 && (position_count_reg < COUNT_W'(MAX_LEN))
                 && ((min_position_reg == '0) || (prefix_sum_reg < min_prefix_reg));
        min_prefix_next   = candidate ? prefix_sum_reg : min_prefix_reg;
        min_position_next = candidate ? position_count_reg : min_position_reg;

        sum_wide = $signed({prefix_sum_reg[SUM_W-1], prefix_sum_reg})
                 + $signed({{(SUM_W-CHAR_W-1){delta[CHAR_W+1]}}, delta});
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            prefix_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                              : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            prefix_sum_next = sum_wide[SUM_W-1:0];
        end

        position_count_next = (position_count_reg < COUNT_W'(MAX_LEN))
                            ? position_count_reg + 1'b1 : position_count_reg;

        // first position of the largest positive suffix sum, else none
        trim_pos = ((min_position_next != '0) && (min_prefix_next < prefix_sum_next))
                 ? min_position_next : '0;
        keep_len = (LEN_W'(trim_pos) < LEN_W'(min_keep_reg)) ? LEN_W'(min_keep_reg)
                                                              : LEN_W'(trim_pos);
        if ((threshold_reg == '0) || (quality >= $signed({2'b00, threshold_reg})))
        begin
            len_val = LEN_W'(position_count_next);
        end
        else if (keep_len > LEN_W'(position_count_next))
        begin
            len_val = LEN_W'(position_count_next);
        end
        else
        begin
            len_val = keep_len;
        end

        out_word_next             = '0;
        out_word_next.quality_out = sanger_reg ? in_char_reg - SANGER_SHIFT : in_char_reg;
        out_word_next.trim_length = in_last_reg ? len_val[TRIM_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg      <= '0;
            sanger_reg         <= 1'b0;
            min_keep_reg       <= MIN_KEEP_RESET;
            in_valid_reg       <= 1'b0;
            position_count_reg <= '0;
            prefix_sum_reg     <= '0;
            min_prefix_reg     <= '0;
            min_position_reg   <= '0;
            out_valid_reg      <= 1'b0;
            out_flag_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_QUALITY_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                    CFG_SANGER_CONVERT:    sanger_reg    <= cfg_data[0];
                    CFG_MIN_KEEP_LENGTH:   min_keep_reg  <= cfg_data[TRIM_W-1:0];
                    default:               ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                out_flag_reg  <= in_last_reg;
                if (in_last_reg)
                begin
                    position_count_reg <= '0;
                    prefix_sum_reg     <= '0;
                    min_prefix_reg     <= '0;
                    min_position_reg   <= '0;
                end
                else
                begin
                    position_count_reg <= position_count_next;
                    prefix_sum_reg     <= prefix_sum_next;
                    min_prefix_reg     <= min_prefix_next;
                    min_position_reg   <= min_position_next;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    `QTPF_ASSERT_ALWAYS(a_count_bound, position_count_reg <= COUNT_W'(MAX_LEN), "position count beyond limit")
    `QTPF_ASSERT_ALWAYS(a_min_before_count, (min_position_reg == '0) || (min_position_reg < position_count_reg), "minimum position not below count")
    `QTPF_ASSERT_NEXT(a_clear_on_last, advance && in_last_reg, (position_count_reg == '0) && (prefix_sum_reg == '0) && (min_position_reg == '0), "read state not cleared after last word")
    `QTPF_ASSERT_ALWAYS(a_length_only_flagged, !out_valid_reg || out_flag_reg || (out_word_reg.trim_length == '0), "trim length set on unflagged word")

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Quality trim point finder core testbench
// Streams reads of quality characters through the core under a range of
// register settings and flow-control patterns. A scoreboard keeps its own
// running prefix sum and minimum search for every read and compares each
// output word with the word it predicts.
// ----------------------------------------------------------------------------

typedef struct {
    logic [7:0]  quality_out;
    logic [10:0] trim_length;
    logic        length_valid;
} trim_word_t;

class trim_length_tracker;
    int         threshold;
    bit         sanger;
    int         min_keep;
    int         count;
    int         running_sum;
    int         lowest_sum;
    int         lowest_pos;
    trim_word_t pending_words[$];
    int         errors;
    int         chars;
    int         reads;
    int         trimmed;
    int         longest;

    function new();
        threshold = 0;
        sanger    = 1'b0;
        min_keep  = int'(qtpf_pkg::MIN_KEEP_RESET);
        errors    = 0;
        chars     = 0;
        reads     = 0;
        trimmed   = 0;
        longest   = 0;
        clear_read();
    endfunction

    function void clear_read();
        count       = 0;
        running_sum = 0;
        lowest_sum  = 0;
        lowest_pos  = 0;
    endfunction

    function void set_reg(qtpf_pkg::cfg_index_t idx, int value);
        case (idx)
            qtpf_pkg::CFG_QUALITY_THRESHOLD: threshold = value & 'h7f;
            qtpf_pkg::CFG_SANGER_CONVERT:    sanger    = value[0];
            qtpf_pkg::CFG_MIN_KEEP_LENGTH:   min_keep  = value & 'h7ff;
            default: ;
        endcase
    endfunction

    function int outstanding();
        return pending_words.size();
    endfunction

    function int offset();
        return sanger ? int'(qtpf_pkg::OFFSET_SANGER_IN) : int'(qtpf_pkg::OFFSET_STD_IN);
    endfunction

    function void note_char(logic [7:0] ch, logic last);
        trim_word_t w;
        int         q;
        int         k;
        int         len;
        int         cut;
        int         sum_hi;
        int         sum_lo;
        sum_hi = (1 << (qtpf_pkg::SUM_W - 1)) - 1;
        sum_lo = -(1 << (qtpf_pkg::SUM_W - 1));
        q = int'(ch) - offset();
        k = count;
        if (k >= 1 && k < qtpf_pkg::MAX_LEN && (lowest_pos == 0 || running_sum < lowest_sum))
        begin
            lowest_sum = running_sum;
            lowest_pos = k;
        end
        running_sum = running_sum + (threshold - q);
        if (running_sum > sum_hi)
            running_sum = sum_hi;
        if (running_sum < sum_lo)
            running_sum = sum_lo;
        if (k < qtpf_pkg::MAX_LEN)
            k++;
        count = k;
        chars++;
        w.quality_out  = sanger ? ch - qtpf_pkg::SANGER_SHIFT : ch;
        w.trim_length  = '0;
        w.length_valid = 1'b0;
        if (last)
        begin
            if (threshold == 0 || q >= threshold)
                len = k;
            else
            begin
                cut = (lowest_pos != 0 && lowest_sum < running_sum) ? lowest_pos : 0;
                len = (cut < min_keep) ? min_keep : cut;
                if (len > k)
                    len = k;
            end
            if (len < k)
                trimmed++;
            if (k > longest)
                longest = k;
            w.trim_length  = len[10:0];
            w.length_valid = 1'b1;
            reads++;
            clear_read();
        end
        pending_words = {pending_words, w};
    endfunction

    function void check_word(logic [7:0] qo, logic [10:0] tl, logic lv);
        trim_word_t w;
        if (pending_words.size() == 0)
        begin
            $error("output word with no character outstanding: quality_out %0d", qo);
            errors++;
            return;
        end
        w = pending_words.pop_front();
        if (qo !== w.quality_out)
        begin
            $error("quality_out: expected %0d, got %0d", w.quality_out, qo);
            errors++;
        end
        if (tl !== w.trim_length)
        begin
            $error("trim_length: expected %0d, got %0d", w.trim_length, tl);
            errors++;
        end
        if (lv !== w.length_valid)
        begin
            $error("length_valid: expected %0d, got %0d", w.length_valid, lv);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int SHAPE_TAIL  = 0;
    localparam int SHAPE_NOISE = 1;
    localparam int SHAPE_FLAT  = 2;
    localparam int STALL_LIMIT = 4000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [qtpf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [qtpf_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;
    int settings       = 0;

    trim_length_tracker tracker = new();

    quality_trim_point_finder_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            tracker.check_word(m_tdata[7:0], m_tdata[18:8], m_tuser);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input qtpf_pkg::cfg_index_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[10:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_reg(idx, value);
    endtask

    task automatic set_config(input int thr, input int sanger, input int min_keep);
        write_reg(qtpf_pkg::CFG_QUALITY_THRESHOLD, thr);
        write_reg(qtpf_pkg::CFG_SANGER_CONVERT, sanger);
        write_reg(qtpf_pkg::CFG_MIN_KEEP_LENGTH, min_keep);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic send_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_char(ch, last);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic send_list(input int chars[$]);
        foreach (chars[i])
            send_char(chars[i][7:0], i == chars.size() - 1);
    endtask

    task automatic send_read(input int len, input int shape, input int fill);
        int split;
        int c;
        split = $urandom_range(0, len);
        for (int i = 0; i < len; i++)
        begin
            case (shape)
                SHAPE_TAIL:
                    if (i < split)
                        c = tracker.offset() + tracker.threshold + $urandom_range(0, 30) - 3;
                    else
                        c = tracker.offset() + tracker.threshold - $urandom_range(0, 30) + 3;
                SHAPE_NOISE:
                    c = $urandom_range(0, 255);
                default:
                    c = fill;
            endcase
            if (c < 0)
                c = 0;
            if (c > 255)
                c = 255;
            send_char(c[7:0], i == len - 1);
        end
    endtask

    task automatic pick_idling(input int mode);
        case (mode)
            0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1:       begin src_idle_pct = 80; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 80; end
            default: begin src_idle_pct = 28; sink_stall_pct = 28; end
        endcase
    endtask

    initial
    begin
        int thr_tab[8];
        int sanger_tab[8];
        int keep_tab[8];
        int sent;
        int len;
        int r;
        thr_tab    = '{20, 30, 0, 127, 15, 1, 0, 0};
        sanger_tab = '{0, 1, 0, 1, 0, 1, 0, 0};
        keep_tab   = '{36, 5, 0, 1024, 0, 1, 0, 0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: trimming off
        send_list('{0, 255, 33});
        drain();

        set_config(40, 0, 0);
        send_list('{33});
        send_list('{83, 83, 43, 43});
        send_list('{43, 83});
        drain();

        set_config(127, 1, 1024);
        send_list('{0, 255});
        send_list('{64, 0});
        drain();

        set_config(1, 1, 3);
        send_list('{96, 96, 64, 64});
        send_list('{255});
        drain();

        for (int p = 0; p < 8; p++)
        begin
            if (p >= 6)
            begin
                thr_tab[p]    = $urandom_range(0, 127);
                sanger_tab[p] = $urandom_range(0, 1);
                r = $urandom_range(0, 3);
                keep_tab[p]   = (r == 0) ? $urandom_range(0, 1024) : $urandom_range(0, 60);
            end
            set_config(thr_tab[p], sanger_tab[p], keep_tab[p]);
            pick_idling(p % 4);
            sent = 0;
            while (sent < 50)
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    len = $urandom_range(1, 12);
                else if (r < 9)
                    len = $urandom_range(13, 60);
                else
                    len = $urandom_range(61, 120);
                r = $urandom_range(0, 9);
                send_read(len, (r < 7) ? SHAPE_TAIL : SHAPE_NOISE, 0);
                sent += len;
            end
            drain();
        end

        // run a flat read of the lowest quality, then a short one
        pick_idling(0);
        set_config(127, 1, 0);
        send_read(40, SHAPE_FLAT, 0);
        send_read(5, SHAPE_TAIL, 0);
        drain();

        repeat (10) @(posedge clk);
        $display("Checked %0d characters in %0d reads (%0d trimmed, longest %0d) over %0d settings",
                 tracker.chars, tracker.reads, tracker.trimmed, tracker.longest, settings);
        $display("Flow control covered free running, idle sender, stalling sink and both mixed");
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* quality_trim_point_finder_core.f */
+incdir+rtl/core
rtl/core/qtpf_pkg.sv
rtl/core/quality_trim_point_finder_core.sv
sim/testbench.sv
